/* src/rau_pkg.sv */
// shared types, constants and helper functions for the rational arithmetic unit
`timescale 1ns / 1ps

package rau_pkg;

  // internal arithmetic word width and the fixed width of the port fields
  localparam int WORD_BITS  = 32;
  localparam int FIELD_BITS = 32;
  localparam int CNT_W      = $clog2(WORD_BITS + 1);

  // operation queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [FIELD_BITS-1:0] field_t;

  // operation codes carried in the kind field
  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_MAC = 3'd4
  } kind_e;

  // classified operation: numerator = x0*y0 +/- x1*y1, denominator = x2*y2
  typedef struct packed {
    word_t x0;
    word_t y0;
    word_t x1;
    word_t y1;
    word_t x2;
    word_t y2;
    logic  sub;
    logic  mac;
    logic  last;
    logic  bypass;
  } op_t;

  // sign-extend a port field and wrap it to the internal word
  function automatic word_t from_field(field_t v);
    logic signed [63:0] ext;
    ext = 64'(signed'(v));
    return ext[WORD_BITS-1:0];
  endfunction

  // low field bits of a word, zero-extended when the word is narrower
  function automatic field_t to_field(word_t v);
    logic [63:0] ext;
    ext = 64'(v);
    return ext[FIELD_BITS-1:0];
  endfunction

  // magnitude of a two's complement word, most negative value stays as is
  function automatic word_t mag(word_t v);
    return v[WORD_BITS-1] ? (~v + word_t'(1)) : v;
  endfunction

endpackage

/* src/rau_if.sv */
// valid/ready channel interfaces for operands and results
`timescale 1ns / 1ps

interface rau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] a_num;
  logic signed [31:0] a_den;
  logic signed [31:0] b_num;
  logic signed [31:0] b_den;
  logic               last;

  modport source (
    output valid, kind, a_num, a_den, b_num, b_den, last,
    input  ready
  );
  modport sink (
    input  valid, kind, a_num, a_den, b_num, b_den, last,
    output ready
  );
endinterface

interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_num;
  logic signed [31:0] r_den;

  modport source (
    output valid, r_num, r_den,
    input  ready
  );
  modport sink (
    input  valid, r_num, r_den,
    output ready
  );
endinterface

/* src/rational_arith_unit.sv */
// Rational arithmetic unit with gcd reduction. Each beat runs three products through one
// shared multiplier, then binary gcd steps and 32 restoring division steps; accumulate
// runs the sequence twice, a zero denominator skips gcd and division, and unused kinds
// go straight to the finish step with a result of 0/1.
// One item per back-end pass; a two-entry queue and an output register decouple the ports.
// Reset (asynchronous, active low) empties the queue and sets the running sum to 0/1.
`timescale 1ns / 1ps

module rational_arith_unit
  import rau_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rau_in_if.sink     in_i,
  rau_out_if.source  out_o
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  op_t  push_op, pop_op;

  // operand classification
  rau_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_op_o    (push_op),
    .push_ready_i (push_ready)
  );

  // decoupling queue
  rau_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_op_i    (push_op),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_op_o     (pop_op),
    .pop_ready_i  (pop_ready)
  );

  // execution and reduction
  rau_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (pop_valid),
    .op_i       (pop_op),
    .op_ready_o (pop_ready),
    .out_o      (out_o)
  );

endmodule

/* src/rau_front.sv */
// front end: takes operand beats and turns each kind into a product schedule
`timescale 1ns / 1ps

module rau_front
  import rau_pkg::*;
(
  rau_in_if.sink in_i,
  output logic   push_valid_o,
  output op_t    push_op_o,
  input  logic   push_ready_i
);

  word_t an, ad, bn, bd;

  // operands wrapped to the internal word
  assign an = from_field(field_t'(in_i.a_num));
  assign ad = from_field(field_t'(in_i.a_den));
  assign bn = from_field(field_t'(in_i.b_num));
  assign bd = from_field(field_t'(in_i.b_den));

  // handshake follows queue space
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  // classify the kind into cross products
  always_comb begin
    push_op_o        = '0;
    push_op_o.last   = in_i.last;
    push_op_o.x2     = ad;
    push_op_o.y2     = bd;
    case (kind_e'(in_i.kind))
      KIND_ADD, KIND_SUB: begin
        push_op_o.x0  = an;
        push_op_o.y0  = bd;
        push_op_o.x1  = bn;
        push_op_o.y1  = ad;
        push_op_o.sub = (kind_e'(in_i.kind) == KIND_SUB);
      end
      KIND_MUL: begin
        push_op_o.x0 = an;
        push_op_o.y0 = bn;
      end
      KIND_DIV: begin
        push_op_o.x0 = an;
        push_op_o.y0 = bd;
        push_op_o.y2 = bn;
      end
      KIND_MAC: begin
        push_op_o.x0  = an;
        push_op_o.y0  = bn;
        push_op_o.mac = 1'b1;
      end
      default: begin
        push_op_o.bypass = 1'b1;
      end
    endcase
  end

endmodule

/* src/rau_queue.sv */
// short operation queue between front and back
`timescale 1ns / 1ps

module rau_queue
  import rau_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  op_t  push_op_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output op_t  pop_op_o,
  input  logic pop_ready_i
);

  op_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");
`endif

endmodule

/* src/rau_back.sv */
// back end: shared multiplier, binary gcd and two-lane divider for reduction
`timescale 1ns / 1ps

module rau_back
  import rau_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_valid_i,
  input  op_t        op_i,
  output logic       op_ready_o,
  rau_out_if.source  out_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_GINIT = 3'd3;
  localparam logic [2:0] S_GCD   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_SIGN  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]       state_q;
  op_t              op_q;
  logic [1:0]       mcnt_q;
  logic             pass2_q;
  word_t            prod_q, num_q, den_q;
  logic             nneg_q, dneg_q;
  word_t            u_q, v_q, g_q;
  logic [CNT_W-1:0] k_q, dcnt_q;
  logic [WORD_BITS:0] rn_q, rd_q;
  word_t            qn_q, qd_q;
  word_t            sum_num_q, sum_den_q;
  logic             out_valid_q;
  word_t            out_num_q, out_den_q;

  word_t              mul_a, mul_b;
  logic [WORD_BITS:0] rn_sh, rd_sh;
  logic               out_free;
  logic               out_load;

  assign op_ready_o  = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_load    = (state_q == S_FIN) && !(op_q.mac && !pass2_q) && out_free;
  assign out_o.valid = out_valid_q;
  assign out_o.r_num = signed'(to_field(out_num_q));
  assign out_o.r_den = signed'(to_field(out_den_q));

  // operand select for the shared multiplier
  always_comb begin
    case (mcnt_q)
      2'd0:    begin mul_a = op_q.x0; mul_b = op_q.y0; end
      2'd1:    begin mul_a = op_q.x1; mul_b = op_q.y1; end
      default: begin mul_a = op_q.x2; mul_b = op_q.y2; end
    endcase
  end

  // partial remainders shifted by one dividend bit
  assign rn_sh = {rn_q[WORD_BITS-1:0], qn_q[WORD_BITS-1]};
  assign rd_sh = {rd_q[WORD_BITS-1:0], qd_q[WORD_BITS-1]};

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q   <= op_i;
        mcnt_q <= '0;
        num_q  <= '0;
        den_q  <= word_t'(1);
      end
      S_MUL: begin
        prod_q <= mul_a * mul_b;
      end
      S_ACC: begin
        case (mcnt_q)
          2'd0:    num_q <= prod_q;
          2'd1:    num_q <= op_q.sub ? (num_q - prod_q) : (num_q + prod_q);
          default: den_q <= prod_q;
        endcase
        mcnt_q <= (mcnt_q == 2'd2) ? 2'd0 : mcnt_q + 2'd1;
      end
      S_GINIT: begin
        nneg_q <= num_q[WORD_BITS-1];
        dneg_q <= den_q[WORD_BITS-1];
        u_q    <= mag(num_q);
        v_q    <= mag(den_q);
        k_q    <= '0;
      end
      S_GCD: begin
        // one binary gcd step
        if (u_q == '0) begin
          g_q <= v_q << k_q;
        end else if (v_q == '0) begin
          g_q <= u_q << k_q;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + CNT_W'(1);
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= (u_q - v_q) >> 1;
        end else begin
          v_q <= (v_q - u_q) >> 1;
        end
        qn_q   <= mag(num_q);
        qd_q   <= mag(den_q);
        rn_q   <= '0;
        rd_q   <= '0;
        dcnt_q <= '0;
      end
      S_DIV: begin
        // restoring division, both lanes share the divisor
        if (rn_sh >= {1'b0, g_q}) begin
          rn_q <= rn_sh - {1'b0, g_q};
          qn_q <= {qn_q[WORD_BITS-2:0], 1'b1};
        end else begin
          rn_q <= rn_sh;
          qn_q <= {qn_q[WORD_BITS-2:0], 1'b0};
        end
        if (rd_sh >= {1'b0, g_q}) begin
          rd_q <= rd_sh - {1'b0, g_q};
          qd_q <= {qd_q[WORD_BITS-2:0], 1'b1};
        end else begin
          rd_q <= rd_sh;
          qd_q <= {qd_q[WORD_BITS-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + CNT_W'(1);
      end
      S_SIGN: begin
        num_q <= nneg_q ? (~qn_q + word_t'(1)) : qn_q;
        den_q <= dneg_q ? (~qd_q + word_t'(1)) : qd_q;
      end
      S_FIN: begin
        // second accumulate pass: running sum plus reduced product
        if (op_q.mac && !pass2_q) begin
          op_q.x0  <= sum_num_q;
          op_q.y0  <= den_q;
          op_q.x1  <= num_q;
          op_q.y1  <= sum_den_q;
          op_q.x2  <= sum_den_q;
          op_q.y2  <= den_q;
          op_q.sub <= 1'b0;
          mcnt_q   <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_num_q <= num_q;
      out_den_q <= den_q;
    end
  end

  // output valid: set on a new result, cleared when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // sequencer and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass2_q     <= 1'b0;
      sum_num_q   <= '0;
      sum_den_q   <= word_t'(1);
    end else begin
      case (state_q)
        S_IDLE: begin
          if (op_valid_i) begin
            state_q <= op_i.bypass ? S_FIN : S_MUL;
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: state_q <= (mcnt_q == 2'd2) ? S_GINIT : S_MUL;
        S_GINIT: state_q <= (den_q == '0) ? S_FIN : S_GCD;
        S_GCD: begin
          if (u_q == '0 || v_q == '0) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt_q == CNT_W'(WORD_BITS - 1)) begin
            state_q <= S_SIGN;
          end
        end
        S_SIGN: state_q <= S_FIN;
        S_FIN: begin
          if (op_q.mac && !pass2_q) begin
            pass2_q <= 1'b1;
            state_q <= S_MUL;
          end else if (out_free) begin
            pass2_q     <= 1'b0;
            state_q     <= S_IDLE;
            if (op_q.mac) begin
              sum_num_q <= op_q.last ? '0 : num_q;
              sum_den_q <= op_q.last ? word_t'(1) : den_q;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> g_q != '0)
    else $error("division started with zero gcd");
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result raised outside the finish step");
  a_idle_pass_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pass2_q)
    else $error("accumulate pass flag left set in idle");
  a_take_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid_i && op_ready_o |=> state_q != S_IDLE)
    else $error("taken operation did not start");
`endif

endmodule
